### hdl/ucsi_pkg.sv
// Package for the UTF-8 / CSI terminal parser: result kinds, parser modes,
// byte codes and default sizes. No dependencies.
`timescale 1ns / 1ps
package ucsi_pkg;
    localparam int DEF_MAX_PARAMS = 32;
    localparam int DEF_MAX_DIGITS = 8;
    localparam int MAX_RESULTS    = 32;

    localparam logic [3:0] KIND_CHAR   = 4'd0;
    localparam logic [3:0] KIND_MOVEXY = 4'd8;
    localparam logic [3:0] KIND_ATTR   = 4'd13;
    localparam logic [3:0] KIND_NONE   = 4'd15;

    localparam logic [2:0] MODE_GROUND = 3'd0;
    localparam logic [2:0] MODE_UTF    = 3'd1;
    localparam logic [2:0] MODE_ESC    = 3'd2;
    localparam logic [2:0] MODE_ESC_O  = 3'd3;
    localparam logic [2:0] MODE_CSI    = 3'd4;
    localparam logic [2:0] MODE_ATTR   = 3'd5;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_COL  = 8'h3A;

    localparam logic [8:0] ARG_NONE = 9'h1FF;

    function automatic logic [3:0] command_kind(input logic [7:0] c);
        logic [3:0] k;
        begin
            unique case (c)
                8'h41: k = 4'd1;
                8'h42: k = 4'd2;
                8'h43: k = 4'd3;
                8'h44: k = 4'd4;
                8'h45: k = 4'd5;
                8'h46: k = 4'd6;
                8'h47: k = 4'd7;
                8'h48: k = KIND_MOVEXY;
                8'h66: k = KIND_MOVEXY;
                8'h4A: k = 4'd9;
                8'h4B: k = 4'd10;
                8'h53: k = 4'd11;
                8'h54: k = 4'd12;
                8'h6D: k = KIND_ATTR;
                default: k = KIND_NONE;
            endcase
            return k;
        end
    endfunction
endpackage

### hdl/utf8_and_csi_terminal_parser.sv
// Top level of the UTF-8 / CSI terminal parser: byte-in, result-out parser
// with the CSI parameters held in a synchronous RAM. Uses ucsi_pkg.
//
// Usage: bytes enter on s_valid/s_ready/s_data_byte; results leave on
// m_valid/m_ready with m_kind, m_code_point, m_first_arg, m_second_arg,
// m_last. m_last marks the final result caused by one byte.
// A char shows in the cycle after its byte is accepted. A command final
// registers its result once parameter 0 is read back from the RAM, and
// for move xy with two or more parameters once parameter 1 is read too.
// An attribute final emits min(params,32) results streamed from the RAM:
// the first once entry 0 is read back, then one per cycle while m_ready holds.
// Throughput: one byte per cycle while the output register is empty or
// drained in the same cycle; s_ready stays low while a command or an
// attribute run is read out. Reset puts the parser in ground with no
// sequence open; the RAM needs no clearing since only written entries are
// read. When m_ready is low the result holds and s_ready drops until it is
// taken.
`timescale 1ns / 1ps
module utf8_and_csi_terminal_parser #(
    parameter int MAX_PARAMS = ucsi_pkg::DEF_MAX_PARAMS,
    parameter int MAX_DIGITS = ucsi_pkg::DEF_MAX_DIGITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [3:0]        m_kind,
    output logic [20:0]       m_code_point,
    output logic signed [8:0] m_first_arg,
    output logic signed [8:0] m_second_arg,
    output logic              m_last
);
    import ucsi_pkg::*;

    localparam int AW = $clog2(MAX_PARAMS);
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int DW = $clog2(MAX_DIGITS + 1);
    localparam int NEMIT = (MAX_PARAMS < MAX_RESULTS) ? MAX_PARAMS : MAX_RESULTS;

    logic [8:0] store [MAX_PARAMS];
    logic [8:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [8:0] wr_data;

    logic [2:0]  mode_reg, mode_next;
    logic [20:0] part_reg, part_next;
    logic [1:0]  left_reg, left_next;
    logic [1:0]  len_reg, len_next;
    logic [7:0]  dval_reg, dval_next;
    logic [DW-1:0] dcnt_reg, dcnt_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    // command fetch: phase 0 idle,1 waiting param0,2 waiting param1
    logic [1:0]  ph_reg, ph_next;
    logic [3:0]  ck_reg, ck_next;
    logic [8:0]  a0_reg, a0_next;
    logic [CW-1:0] idx_reg, idx_next; // attribute emit index
    logic        rdv_reg, rdv_next;   // rd_data valid for attribute

    logic        ov_reg, ov_next;
    logic [3:0]  ok_reg, ok_next;
    logic [20:0] ocp_reg, ocp_next;
    logic [8:0]  oa_reg, oa_next, ob_reg, ob_next;
    logic        ol_reg, ol_next;

    logic out_free, busy, acc;
    logic [7:0] c;
    logic [11:0] dig10;
    logic [20:0] shifted, v;
    logic [8:0] pval;

    assign out_free = !ov_reg || m_ready;
    assign busy = (ph_reg != 2'd0) || (mode_reg == MODE_ATTR);
    assign s_ready = out_free && !busy;
    assign acc = s_valid && s_ready;
    assign c = s_data_byte;

    // a final written at the same edge as its read is forwarded
    always_ff @(posedge aclk) begin
        if (wr_en) store[wr_addr] <= wr_data;
        rd_data_reg <= (wr_en && wr_addr == rd_addr) ? wr_data : store[rd_addr];
    end

    always_comb begin
        mode_next = mode_reg; part_next = part_reg; left_next = left_reg;
        len_next = len_reg; dval_next = dval_reg; dcnt_next = dcnt_reg;
        pcnt_next = pcnt_reg; ph_next = ph_reg; ck_next = ck_reg;
        a0_next = a0_reg; idx_next = idx_reg; rdv_next = 1'b0;
        ov_next = ov_reg && !m_ready;
        ok_next = ok_reg; ocp_next = ocp_reg; oa_next = oa_reg;
        ob_next = ob_reg; ol_next = ol_reg;
        wr_en = 1'b0; wr_addr = pcnt_reg[AW-1:0]; wr_data = ARG_NONE;
        rd_addr = '0;
        dig10 = {4'd0, dval_reg} * 12'd10 + {8'd0, c[3:0]};
        shifted = 21'({c[5:0]}) << (6 * (left_reg - 2'd1));
        v = part_reg | shifted;
        pval = (dcnt_reg == '0) ? ARG_NONE : {1'b0, dval_reg};

        if (ph_reg == 2'd1) begin
            // param0 arrives this cycle
            if (ck_reg == KIND_MOVEXY && pcnt_reg >= CW'(2)) begin
                a0_next = rd_data_reg; ph_next = 2'd2;
            end else if (out_free) begin
                ov_next = 1'b1; ok_next = ck_reg; ocp_next = '0;
                oa_next = rd_data_reg; ob_next = ARG_NONE; ol_next = 1'b1;
                ph_next = 2'd0;
            end else begin
                rd_addr = '0; ph_next = 2'd1;
            end
            if (ph_next == 2'd2) rd_addr = AW'(1);
        end else if (ph_reg == 2'd2) begin
            rd_addr = AW'(1);
            if (out_free) begin
                ov_next = 1'b1; ok_next = ck_reg; ocp_next = '0;
                oa_next = a0_reg; ob_next = rd_data_reg; ol_next = 1'b1;
                ph_next = 2'd0;
            end
        end else if (mode_reg == MODE_ATTR) begin
            // rd_data holds entry idx when rdv set
            rd_addr = idx_reg[AW-1:0];
            rdv_next = 1'b1;
            if (rdv_reg && out_free) begin
                ov_next = 1'b1; ok_next = KIND_ATTR; ocp_next = '0;
                oa_next = rd_data_reg; ob_next = ARG_NONE;
                ol_next = (idx_reg + CW'(1) >= CW'(NEMIT)) ||
                          (idx_reg + CW'(1) >= pcnt_reg);
                if (ol_next) begin
                    mode_next = MODE_GROUND;
                    rdv_next = 1'b0;
                end else begin
                    idx_next = idx_reg + CW'(1);
                    rd_addr = idx_next[AW-1:0];
                end
            end else if (rdv_reg) begin
                rdv_next = 1'b1;
            end
        end else if (acc) begin
            unique case (mode_reg)
                MODE_UTF: begin
                    if (c < 8'h80 || c > 8'hBF) begin
                        mode_next = MODE_GROUND;
                    end else begin
                        left_next = left_reg - 2'd1;
                        part_next = v;
                        if (left_reg == 2'd1) begin
                            mode_next = MODE_GROUND;
                            if (!((len_reg == 2'd1 && v < 21'h80) ||
                                  (len_reg == 2'd2 && (v < 21'h800 ||
                                   (v >= 21'hD800 && v <= 21'hDFFF))) ||
                                  (len_reg == 2'd3 && (v < 21'h10000 ||
                                   v >= 21'h110000)))) begin
                                ov_next = 1'b1; ok_next = KIND_CHAR;
                                ocp_next = v; oa_next = '0; ob_next = '0;
                                ol_next = 1'b1;
                            end
                        end
                    end
                end
                MODE_ESC: begin
                    if (c == CH_O) mode_next = MODE_ESC_O;
                    else if (c == CH_LBR) begin
                        mode_next = MODE_CSI; pcnt_next = '0;
                        dval_next = '0; dcnt_next = '0;
                    end else mode_next = MODE_GROUND;
                end
                MODE_ESC_O: mode_next = MODE_GROUND;
                MODE_CSI: begin
                    if (c >= 8'h30 && c <= 8'h39) begin
                        dval_next = (dig10 > 12'd255) ? 8'hFF : dig10[7:0];
                        dcnt_next = dcnt_reg + DW'(1);
                        if (dcnt_next >= DW'(MAX_DIGITS)) mode_next = MODE_GROUND;
                    end else if (dcnt_reg != '0 && dval_reg == 8'hFF) begin
                        mode_next = MODE_GROUND;
                    end else begin
                        dval_next = '0; dcnt_next = '0;
                        wr_en = (pcnt_reg < CW'(MAX_PARAMS));
                        wr_data = pval;
                        pcnt_next = pcnt_reg + CW'(1);
                        if (c == CH_SEMI || c == CH_COL) begin
                            if (pcnt_next >= CW'(MAX_PARAMS)) mode_next = MODE_GROUND;
                        end else begin
                            mode_next = MODE_GROUND;
                            ck_next = command_kind(c);
                            if (ck_next == KIND_ATTR) begin
                                mode_next = MODE_ATTR; idx_next = '0;
                            end else if (ck_next != KIND_NONE) begin
                                ph_next = 2'd1;
                            end
                        end
                    end
                end
                default: begin
                    if (c == CH_ESC) mode_next = MODE_ESC;
                    else if (c < 8'h80) begin
                        ov_next = 1'b1; ok_next = KIND_CHAR; ocp_next = {13'd0, c};
                        oa_next = '0; ob_next = '0; ol_next = 1'b1;
                    end else if (c >= 8'hC2 && c <= 8'hDF) begin
                        part_next = {10'd0, c[4:0], 6'd0}; left_next = 2'd1;
                        len_next = 2'd1; mode_next = MODE_UTF;
                    end else if (c >= 8'hE0 && c <= 8'hEF) begin
                        part_next = {5'd0, c[3:0], 12'd0}; left_next = 2'd2;
                        len_next = 2'd2; mode_next = MODE_UTF;
                    end else if (c >= 8'hF0 && c <= 8'hF7) begin
                        part_next = {c[2:0], 18'd0}; left_next = 2'd3;
                        len_next = 2'd3; mode_next = MODE_UTF;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_GROUND; left_reg <= '0; len_reg <= '0;
            part_reg <= '0; dval_reg <= '0; dcnt_reg <= '0; pcnt_reg <= '0;
            ph_reg <= '0; idx_reg <= '0; rdv_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            mode_reg <= mode_next; left_reg <= left_next; len_reg <= len_next;
            part_reg <= part_next; dval_reg <= dval_next; dcnt_reg <= dcnt_next;
            pcnt_reg <= pcnt_next; ph_reg <= ph_next; idx_reg <= idx_next;
            rdv_reg <= rdv_next; ov_reg <= ov_next;
        end
        ck_reg <= ck_next; a0_reg <= a0_next; ok_reg <= ok_next;
        ocp_reg <= ocp_next; oa_reg <= oa_next; ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    assign m_valid = ov_reg;
    assign m_kind = ok_reg;
    assign m_code_point = ocp_reg;
    assign m_first_arg = oa_reg;
    assign m_second_arg = ob_reg;
    assign m_last = ol_reg;
endmodule
